// ===== design/i2cm_pkg.sv =====
`default_nettype none

package i2cm_pkg;

    localparam int TICK_COUNTER_WIDTH_DEF = 16;
    localparam int PHASE_TICKS_WIDTH      = 16;
    localparam logic [PHASE_TICKS_WIDTH-1:0] PHASE_TICKS_RESET = 16'd160;

    localparam logic [4:0] WRITE_PHASES = 5'd27;
    localparam logic [4:0] READ_PHASES  = 5'd19;
    localparam logic [4:0] SHORT_PHASES = 5'd3;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4,
        CMD_POLL  = 3'd5
    } cmd_t;

    // Bus engine state apart from the tick counter, whose width is a parameter.
    typedef struct packed {
        logic       scl_level;
        logic       sda_pull_low;
        cmd_t       active_command;
        logic [4:0] phase_index;
        logic [7:0] shift_bits;
        logic       ack_bit;
        logic       nack_choice;
    } eng_state_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       ack_seen;
        logic       cmd_rejected;
    } result_t;

endpackage

`default_nettype wire

// ===== design/i2cm_step.sv =====
`default_nettype none

module i2cm_step #(
    parameter int TICK_COUNTER_WIDTH = i2cm_pkg::TICK_COUNTER_WIDTH_DEF
) (
    input  var i2cm_pkg::eng_state_t      state_reg,
    input  wire [TICK_COUNTER_WIDTH-1:0]  tick_reg,
    input  wire [TICK_COUNTER_WIDTH-1:0]  limit,
    input  wire [2:0]                     mode,
    input  wire [7:0]                     write_byte,
    input  wire                           send_nack,
    input  wire                           sda_in,
    output i2cm_pkg::eng_state_t          state_next,
    output logic [TICK_COUNTER_WIDTH-1:0] tick_next,
    output i2cm_pkg::result_t             res
);
    import i2cm_pkg::*;

    // Line levels at the beginning of phase p of the active command.
    function automatic eng_state_t enter_phase(eng_state_t s, logic [4:0] p);
        logic [9:0] prod;
        logic [2:0] bit_q;
        logic [4:0] rem;
        eng_state_t o;
        o     = s;
        // p / 3 for p below 24 as a multiply by 11/32.
        prod  = {5'd0, p} * 10'd11;
        bit_q = prod[7:5];
        rem   = p - 5'({2'd0, bit_q} * 5'd3);
        unique case (s.active_command)
            CMD_START: begin
                if (p == 5'd0) begin
                    o.sda_pull_low = 1'b0;
                    o.scl_level    = 1'b1;
                end else if (p == 5'd1) begin
                    o.sda_pull_low = 1'b1;
                end else begin
                    o.scl_level = 1'b0;
                end
            end
            CMD_STOP: begin
                if (p == 5'd0) o.sda_pull_low = 1'b1;
                else if (p == 5'd1) o.scl_level = 1'b1;
                else o.sda_pull_low = 1'b0;
            end
            CMD_WRITE: begin
                if (p < 5'd24) begin
                    if (rem == 5'd0) o.sda_pull_low = ~s.shift_bits[3'd7 - bit_q];
                    else o.scl_level = (rem == 5'd1);
                end else if (p == 5'd24) begin
                    o.sda_pull_low = 1'b0;
                end else if (p == 5'd25) begin
                    o.scl_level = 1'b1;
                end else begin
                    o.scl_level = 1'b0;
                end
            end
            CMD_READ: begin
                if (p < 5'd16) o.scl_level = ~p[0];
                else if (p == 5'd16) o.sda_pull_low = ~s.nack_choice;
                else if (p == 5'd17) o.scl_level = 1'b1;
                else o.scl_level = 1'b0;
            end
            default: begin
                if (p == 5'd0) o.sda_pull_low = 1'b0;
                else if (p == 5'd1) o.scl_level = 1'b1;
                else o.scl_level = 1'b0;
            end
        endcase
        return o;
    endfunction

    logic [TICK_COUNTER_WIDTH-1:0] tick_inc;
    logic [4:0]                    phase_inc;
    logic [4:0]                    phase_total;
    eng_state_t                    s;
    logic                          mode_valid;

    assign tick_inc   = tick_reg + 1'b1;
    assign phase_inc  = state_reg.phase_index + 5'd1;
    assign mode_valid = (mode >= 3'(CMD_START)) && (mode <= 3'(CMD_POLL));

    always_comb begin
        unique case (state_reg.active_command)
            CMD_WRITE: phase_total = WRITE_PHASES;
            CMD_READ:  phase_total = READ_PHASES;
            default:   phase_total = SHORT_PHASES;
        endcase
    end

    always_comb begin
        s         = state_reg;
        tick_next = tick_reg;
        res       = '0;
        if (state_reg.active_command != CMD_NONE) begin
            res.cmd_rejected = (mode != 3'(CMD_NONE));
            tick_next        = tick_inc;
            if (tick_inc >= limit) begin
                // SDA is taken as write/poll ACK and read bit phases end.
                if (s.active_command == CMD_WRITE && s.phase_index == 5'd25) begin
                    s.ack_bit = sda_in;
                end else if (s.active_command == CMD_POLL && s.phase_index == 5'd1) begin
                    s.ack_bit = sda_in;
                end else if (s.active_command == CMD_READ && s.phase_index < 5'd16
                             && !s.phase_index[0]) begin
                    s.shift_bits = {s.shift_bits[6:0], sda_in};
                end
                tick_next     = '0;
                s.phase_index = phase_inc;
                if (phase_inc >= phase_total) begin
                    res.done_res = 1'b1;
                    if (s.active_command == CMD_READ) begin
                        res.read_byte  = s.shift_bits;
                        s.sda_pull_low = 1'b0;
                    end else if (s.active_command == CMD_WRITE
                                 || s.active_command == CMD_POLL) begin
                        res.ack_seen = s.ack_bit;
                    end
                    s.active_command = CMD_NONE;
                    s.phase_index    = 5'd0;
                end else begin
                    s = enter_phase(s, phase_inc);
                end
            end
        end else if (mode_valid) begin
            s.active_command = cmd_t'(mode);
            s.phase_index    = 5'd0;
            s.nack_choice    = send_nack;
            tick_next        = '0;
            if (mode == 3'(CMD_WRITE)) begin
                s.shift_bits = write_byte;
            end else if (mode == 3'(CMD_READ)) begin
                s.shift_bits   = 8'd0;
                s.sda_pull_low = 1'b0;
            end
            s = enter_phase(s, 5'd0);
        end
        res.scl_out       = s.scl_level;
        res.sda_drive_low = s.sda_pull_low;
        res.busy_res      = (s.active_command != CMD_NONE);
        state_next        = s;
    end

endmodule

`default_nettype wire

// ===== design/i2cm_out_stage.sv =====
`default_nettype none

module i2cm_out_stage (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                load,
    input  var i2cm_pkg::result_t res,
    output logic               space,
    output logic               m_valid,
    input  wire                m_ready,
    output logic               m_scl_out,
    output logic               m_sda_drive_low,
    output logic               m_busy_res,
    output logic               m_done_res,
    output logic [7:0]         m_read_byte,
    output logic               m_ack_seen,
    output logic               m_cmd_rejected
);
    import i2cm_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // The register takes a new item in the same cycle its old one leaves.
    assign space      = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= res;
        end
    end

    assign m_valid         = valid_reg;
    assign m_scl_out       = data_reg.scl_out;
    assign m_sda_drive_low = data_reg.sda_drive_low;
    assign m_busy_res      = data_reg.busy_res;
    assign m_done_res      = data_reg.done_res;
    assign m_read_byte     = data_reg.read_byte;
    assign m_ack_seen      = data_reg.ack_seen;
    assign m_cmd_rejected  = data_reg.cmd_rejected;

endmodule

`default_nettype wire

// ===== design/i2c_master_bit_engine.sv =====
// A result item is registered and appears on the m_ side in the cycle after its input item
// is accepted. Throughput: one item per cycle while no result is pending or m_ready is high;
// the engine state and the result register both update on each accepted item, and a new
// item is taken while the previous result is being taken. Reset (aresetn low at a clock
// edge): engine idle, SCL high, SDA released, no result pending, phase_ticks back to 160.
`default_nettype none

module i2c_master_bit_engine #(
    parameter int TICK_COUNTER_WIDTH = i2cm_pkg::TICK_COUNTER_WIDTH_DEF
) (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        cfg_valid,
    output logic       cfg_ready,
    input  wire [15:0] cfg_data,
    input  wire        s_valid,
    output logic       s_ready,
    input  wire [2:0]  s_mode,
    input  wire [7:0]  s_write_byte,
    input  wire        s_send_nack,
    input  wire        s_sda_in,
    output logic       m_valid,
    input  wire        m_ready,
    output logic       m_scl_out,
    output logic       m_sda_drive_low,
    output logic       m_busy_res,
    output logic       m_done_res,
    output logic [7:0] m_read_byte,
    output logic       m_ack_seen,
    output logic       m_cmd_rejected
);
    import i2cm_pkg::*;

    localparam int LW = (TICK_COUNTER_WIDTH > PHASE_TICKS_WIDTH) ?
                        TICK_COUNTER_WIDTH : PHASE_TICKS_WIDTH;

    logic [PHASE_TICKS_WIDTH-1:0]  phase_ticks_reg;
    eng_state_t                    state_reg;
    eng_state_t                    state_next;
    logic [TICK_COUNTER_WIDTH-1:0] tick_reg;
    logic [TICK_COUNTER_WIDTH-1:0] tick_next;
    logic [LW-1:0]                 ticks_ext;
    logic [LW-1:0]                 count_max;
    logic [LW-1:0]                 limit_ext;
    logic [TICK_COUNTER_WIDTH-1:0] limit;
    result_t                       res;
    logic                          s_accept;

    assign cfg_ready = 1'b1;
    assign s_accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_ticks_reg <= PHASE_TICKS_RESET;
        end else if (cfg_valid) begin
            phase_ticks_reg <= cfg_data;
        end
    end

    // A zero phase length counts as one; a length beyond the counter saturates.
    assign ticks_ext = LW'(phase_ticks_reg);
    assign count_max = LW'({TICK_COUNTER_WIDTH{1'b1}});

    always_comb begin
        if (ticks_ext == '0) limit_ext = LW'(1);
        else if (ticks_ext > count_max) limit_ext = count_max;
        else limit_ext = ticks_ext;
    end

    assign limit = limit_ext[TICK_COUNTER_WIDTH-1:0];

    i2cm_step #(
        .TICK_COUNTER_WIDTH(TICK_COUNTER_WIDTH)
    ) u_step (
        .state_reg (state_reg),
        .tick_reg  (tick_reg),
        .limit     (limit),
        .mode      (s_mode),
        .write_byte(s_write_byte),
        .send_nack (s_send_nack),
        .sda_in    (s_sda_in),
        .state_next(state_next),
        .tick_next (tick_next),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.scl_level      <= 1'b1;
            state_reg.sda_pull_low   <= 1'b0;
            state_reg.active_command <= CMD_NONE;
            state_reg.phase_index    <= 5'd0;
            state_reg.shift_bits     <= 8'd0;
            state_reg.ack_bit        <= 1'b0;
            state_reg.nack_choice    <= 1'b0;
            tick_reg                 <= '0;
        end else if (s_accept) begin
            state_reg <= state_next;
            tick_reg  <= tick_next;
        end
    end

    i2cm_out_stage u_out (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (s_accept),
        .res            (res),
        .space          (s_ready),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_scl_out      (m_scl_out),
        .m_sda_drive_low(m_sda_drive_low),
        .m_busy_res     (m_busy_res),
        .m_done_res     (m_done_res),
        .m_read_byte    (m_read_byte),
        .m_ack_seen     (m_ack_seen),
        .m_cmd_rejected (m_cmd_rejected)
    );

endmodule

`default_nettype wire

// ===== design/i2cm_checker.sv =====
`default_nettype none

module i2cm_checker (
    input wire       aclk,
    input wire       aresetn,
    input wire       s_valid,
    input wire       s_ready,
    input wire       m_valid,
    input wire       m_ready,
    input wire       m_scl_out,
    input wire       m_sda_drive_low,
    input wire       m_busy_res,
    input wire       m_done_res,
    input wire [7:0] m_read_byte,
    input wire       m_ack_seen,
    input wire       m_cmd_rejected
);

    // A finished command leaves the engine idle.
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_done_res) |-> !m_busy_res)
        else $error("done item still reports busy");

    // Read data and ACK are only reported with done.
    a_byte_with_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_read_byte != 8'd0) |-> m_done_res)
        else $error("read byte outside done");

    a_ack_with_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ack_seen) |-> m_done_res)
        else $error("ack outside done");

    // A stalled result item holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_scl_out)
            && $stable(m_sda_drive_low) && $stable(m_busy_res)
            && $stable(m_done_res) && $stable(m_read_byte)
            && $stable(m_ack_seen) && $stable(m_cmd_rejected)))
        else $error("stalled result item changed");

endmodule

bind i2c_master_bit_engine i2cm_checker u_checker (.*);

`default_nettype wire

// ===== tb/i2c_bit_checker.sv =====
module i2c_bit_checker (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        cfg_valid,
    input  wire        cfg_ready,
    input  wire [15:0] cfg_data,
    input  wire        s_valid,
    input  wire        s_ready,
    input  wire [2:0]  s_mode,
    input  wire [7:0]  s_write_byte,
    input  wire        s_send_nack,
    input  wire        s_sda_in,
    input  wire        m_valid,
    input  wire        m_ready,
    input  wire        m_scl_out,
    input  wire        m_sda_drive_low,
    input  wire        m_busy_res,
    input  wire        m_done_res,
    input  wire [7:0]  m_read_byte,
    input  wire        m_ack_seen,
    input  wire        m_cmd_rejected,
    output int         fail_count,
    output int         results_owed
);
    import i2cm_pkg::*;

    // Shadow copy of the bus engine.
    logic [15:0] phase_len;
    logic        scl_lvl;
    logic        sda_low;
    cmd_t        cur_cmd;
    logic [4:0]  phase_no;
    logic [15:0] tick_cnt;
    logic [7:0]  shreg;
    logic        ack_latch;
    logic        nack_latch;

    result_t     tick_results[$];
    result_t     predicted;
    result_t     oldest;
    int          mismatches = 0;
    int          owed = 0;

    assign fail_count   = mismatches;
    assign results_owed = owed;

    function automatic logic [4:0] phases_of(input cmd_t c);
        if (c == CMD_WRITE) return WRITE_PHASES;
        if (c == CMD_READ) return READ_PHASES;
        return SHORT_PHASES;
    endfunction

    // Line levels at the start of the current phase.
    task automatic enter_phase();
        int p;
        p = phase_no;
        case (cur_cmd)
            CMD_START: begin
                if (p == 0) begin
                    sda_low = 1'b0;
                    scl_lvl = 1'b1;
                end else if (p == 1) sda_low = 1'b1;
                else scl_lvl = 1'b0;
            end
            CMD_STOP: begin
                if (p == 0) sda_low = 1'b1;
                else if (p == 1) scl_lvl = 1'b1;
                else sda_low = 1'b0;
            end
            CMD_WRITE: begin
                if (p < 24) begin
                    if (p % 3 == 0) sda_low = ~shreg[7 - p / 3];
                    else scl_lvl = (p % 3 == 1);
                end else if (p == 24) sda_low = 1'b0;
                else if (p == 25) scl_lvl = 1'b1;
                else scl_lvl = 1'b0;
            end
            CMD_READ: begin
                if (p < 16) scl_lvl = ~phase_no[0];
                else if (p == 16) sda_low = ~nack_latch;
                else if (p == 17) scl_lvl = 1'b1;
                else scl_lvl = 1'b0;
            end
            default: begin
                if (p == 0) sda_low = 1'b0;
                else if (p == 1) scl_lvl = 1'b1;
                else scl_lvl = 1'b0;
            end
        endcase
    endtask

    // SDA is taken at the end of the ACK phase of a write or poll and of each SCL-high bit phase of a read.
    task automatic sample_sda(input logic sd);
        if (cur_cmd == CMD_WRITE && phase_no == 5'd25) ack_latch = sd;
        else if (cur_cmd == CMD_POLL && phase_no == 5'd1) ack_latch = sd;
        else if (cur_cmd == CMD_READ && phase_no < 5'd16 && !phase_no[0])
            shreg = {shreg[6:0], sd};
    endtask

    task automatic advance_tick(input logic [2:0] md, input logic [7:0] wb, input logic nk,
                                input logic sd, output result_t r);
        logic [15:0] lim;
        r = '0;
        lim = (phase_len == 16'd0) ? 16'd1 : phase_len;
        if (cur_cmd != CMD_NONE) begin
            r.cmd_rejected = (md != CMD_NONE);
            tick_cnt = tick_cnt + 16'd1;
            if (tick_cnt >= lim) begin
                sample_sda(sd);
                tick_cnt = '0;
                phase_no = phase_no + 5'd1;
                if (phase_no >= phases_of(cur_cmd)) begin
                    r.done_res = 1'b1;
                    if (cur_cmd == CMD_READ) begin
                        r.read_byte = shreg;
                        sda_low = 1'b0;
                    end else if (cur_cmd == CMD_WRITE || cur_cmd == CMD_POLL) begin
                        r.ack_seen = ack_latch;
                    end
                    cur_cmd = CMD_NONE;
                    phase_no = '0;
                end else begin
                    enter_phase();
                end
            end
        end else if (md >= CMD_START && md <= CMD_POLL) begin
            cur_cmd = cmd_t'(md);
            phase_no = '0;
            tick_cnt = '0;
            nack_latch = nk;
            if (md == CMD_WRITE) shreg = wb;
            else if (md == CMD_READ) begin
                shreg = '0;
                sda_low = 1'b0;
            end
            enter_phase();
        end
        r.scl_out = scl_lvl;
        r.sda_drive_low = sda_low;
        r.busy_res = (cur_cmd != CMD_NONE);
    endtask

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            phase_len = PHASE_TICKS_RESET;
            scl_lvl = 1'b1;
            sda_low = 1'b0;
            cur_cmd = CMD_NONE;
            phase_no = '0;
            tick_cnt = '0;
            shreg = '0;
            ack_latch = 1'b0;
            nack_latch = 1'b0;
            tick_results.delete();
            owed <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (tick_results.size() == 0) begin
                    $display("%0t: result item with nothing expected", $time);
                    mismatches++;
                end else begin
                    oldest = tick_results.pop_front();
                    check_field("scl_out", oldest.scl_out, m_scl_out);
                    check_field("sda_drive_low", oldest.sda_drive_low, m_sda_drive_low);
                    check_field("busy_res", oldest.busy_res, m_busy_res);
                    check_field("done_res", oldest.done_res, m_done_res);
                    check_field("read_byte", oldest.read_byte, m_read_byte);
                    check_field("ack_seen", oldest.ack_seen, m_ack_seen);
                    check_field("cmd_rejected", oldest.cmd_rejected, m_cmd_rejected);
                end
            end
            if (cfg_valid && cfg_ready) phase_len = cfg_data;
            if (s_valid && s_ready) begin
                advance_tick(s_mode, s_write_byte, s_send_nack, s_sda_in, predicted);
                tick_results.push_back(predicted);
            end
            owed <= tick_results.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    import i2cm_pkg::*;

    localparam int CYCLE_LIMIT = 100_000;
    localparam logic [2:0] MODE_UNDEF_6 = 3'd6;
    localparam logic [2:0] MODE_UNDEF_7 = 3'd7;
    localparam int STALL_CYCLES = 60;

    typedef enum {SDA_RANDOM, SDA_HIGH, SDA_LOW} sda_pattern_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [15:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic [2:0]  s_mode = CMD_NONE;
    logic [7:0]  s_write_byte = '0;
    logic        s_send_nack = 1'b0;
    logic        s_sda_in = 1'b1;
    logic        m_ready = 1'b0;

    wire         cfg_ready;
    wire         s_ready;
    wire         m_valid;
    wire         m_scl_out;
    wire         m_sda_drive_low;
    wire         m_busy_res;
    wire         m_done_res;
    wire [7:0]   m_read_byte;
    wire         m_ack_seen;
    wire         m_cmd_rejected;

    int          fail_count;
    int          results_owed;
    int          cycle_count = 0;
    int          send_idle_pct = 15;
    int          recv_idle_pct = 71;
    int          stall_token = 0;
    int          stall_served = 0;
    int          hold_left = 0;
    int          sent_items = 0;
    int          cur_pt = PHASE_TICKS_RESET;

    always #5 aclk = ~aclk;

    i2c_master_bit_engine dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_write_byte    (s_write_byte),
        .s_send_nack     (s_send_nack),
        .s_sda_in        (s_sda_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_scl_out       (m_scl_out),
        .m_sda_drive_low (m_sda_drive_low),
        .m_busy_res      (m_busy_res),
        .m_done_res      (m_done_res),
        .m_read_byte     (m_read_byte),
        .m_ack_seen      (m_ack_seen),
        .m_cmd_rejected  (m_cmd_rejected)
    );

    i2c_bit_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_write_byte    (s_write_byte),
        .s_send_nack     (s_send_nack),
        .s_sda_in        (s_sda_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_scl_out       (m_scl_out),
        .m_sda_drive_low (m_sda_drive_low),
        .m_busy_res      (m_busy_res),
        .m_done_res      (m_done_res),
        .m_read_byte     (m_read_byte),
        .m_ack_seen      (m_ack_seen),
        .m_cmd_rejected  (m_cmd_rejected),
        .fail_count      (fail_count),
        .results_owed    (results_owed)
    );

    // Result side: random back-pressure, plus a long hold-off whenever one is requested.
    always @(posedge aclk) begin
        if (stall_served != stall_token) begin
            stall_served <= stall_token;
            hold_left <= STALL_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int ticks_per_phase(input int pt);
        return (pt == 0) ? 1 : pt;
    endfunction

    function automatic int cmd_phases(input logic [2:0] md);
        if (md == CMD_WRITE) return WRITE_PHASES;
        if (md == CMD_READ) return READ_PHASES;
        return SHORT_PHASES;
    endfunction

    function automatic sda_pattern_t random_sda_pattern();
        case ($urandom_range(3, 0))
            2: return SDA_HIGH;
            3: return SDA_LOW;
            default: return SDA_RANDOM;
        endcase
    endfunction

    task automatic send_tick(input logic [2:0] md, input logic [7:0] wb, input logic nk,
                             input sda_pattern_t sp);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= md;
        s_write_byte <= wb;
        s_send_nack <= nk;
        s_sda_in <= (sp == SDA_HIGH) ? 1'b1 : (sp == SDA_LOW) ? 1'b0 : 1'($urandom);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_items++;
    endtask

    // A command item followed by gap ticks; noise commands land only while still busy.
    task automatic run_cmd(input logic [2:0] md, input logic [7:0] wb, input logic nk,
                           input sda_pattern_t sp, input int gap, input int noise_pct);
        logic [2:0] fill_mode;
        send_tick(md, wb, nk, sp);
        for (int i = 0; i < gap; i++) begin
            fill_mode = CMD_NONE;
            if (i < gap - 2 && $urandom_range(99, 0) < noise_pct)
                fill_mode = 3'($urandom_range(7, 1));
            send_tick(fill_mode, 8'($urandom), 1'($urandom), sp);
        end
    endtask

    task automatic wait_all_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_owed != 0);
        repeat (3) @(posedge aclk);
    endtask

    // Reprogram once every result item has been taken; a running command simply
    // continues with the new phase length.
    task automatic set_phase_ticks(input logic [15:0] value);
        wait_all_results();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        cur_pt = value;
    endtask

    task automatic random_items(input int count);
        int stop_at;
        int len;
        int gap;
        logic [2:0] md;
        stop_at = sent_items + count;
        while (sent_items < stop_at) begin
            if ($urandom_range(99, 0) < 80) begin
                md = 3'($urandom_range(CMD_POLL, CMD_START));
                len = cmd_phases(md) * ticks_per_phase(cur_pt);
                if ($urandom_range(9, 0) == 0) gap = $urandom_range(len - 1, 0);
                else gap = len + $urandom_range(2, 0);
                run_cmd(md, 8'($urandom), 1'($urandom), random_sda_pattern(), gap, 6);
            end else begin
                send_tick(3'($urandom_range(7, 0)), 8'($urandom), 1'($urandom), SDA_RANDOM);
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Default phase length straight out of reset: the first phase of the start
        // ends on its 160th tick, and the rest runs with one tick per phase.
        run_cmd(CMD_START, 8'h00, 1'b0, SDA_RANDOM, PHASE_TICKS_RESET + 1, 0);
        set_phase_ticks(16'd1);
        run_cmd(CMD_NONE, 8'h00, 1'b0, SDA_RANDOM, 3, 0);

        run_cmd(CMD_START, 8'h00, 1'b0, SDA_RANDOM, 3, 0);
        run_cmd(CMD_WRITE, 8'hFF, 1'b0, SDA_LOW, 27, 0);
        run_cmd(CMD_WRITE, 8'h00, 1'b1, SDA_HIGH, 27, 0);
        run_cmd(CMD_READ, 8'h00, 1'b0, SDA_HIGH, 19, 0);
        run_cmd(CMD_READ, 8'hFF, 1'b1, SDA_LOW, 19, 0);
        run_cmd(CMD_POLL, 8'h00, 1'b0, SDA_HIGH, 3, 0);
        run_cmd(CMD_POLL, 8'h00, 1'b0, SDA_LOW, 3, 0);
        send_tick(MODE_UNDEF_6, 8'h00, 1'b0, SDA_RANDOM);
        send_tick(MODE_UNDEF_7, 8'hFF, 1'b1, SDA_RANDOM);
        // Commands arriving in the middle of a write are rejected.
        run_cmd(CMD_WRITE, 8'h5A, 1'b0, SDA_RANDOM, 2, 0);
        send_tick(CMD_READ, 8'h00, 1'b0, SDA_RANDOM);
        send_tick(MODE_UNDEF_7, 8'h00, 1'b0, SDA_RANDOM);
        run_cmd(CMD_NONE, 8'h00, 1'b0, SDA_RANDOM, 23, 0);
        // A stop arriving on the tick the poll finishes is rejected as well.
        run_cmd(CMD_POLL, 8'h00, 1'b0, SDA_RANDOM, 2, 0);
        run_cmd(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM, 0, 0);
        run_cmd(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM, 3, 0);

        random_items(45);
        stall_token++;
        random_items(45);

        set_phase_ticks(16'($urandom_range(3, 2)));
        send_idle_pct = 71;
        recv_idle_pct = 15;
        random_items(45);
        wait_all_results();
        random_items(45);

        set_phase_ticks(16'd0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_items(45);
        stall_token++;
        random_items(45);

        // Longest phase: the start stays in its first phase for all the ticks sent here.
        set_phase_ticks(16'hFFFF);
        run_cmd(CMD_START, 8'h00, 1'b0, SDA_RANDOM, 40, 1);
        wait_all_results();

        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
